/* hw/rtl/assert_macros.svh */
// assertion helpers, clocked on clk and held off while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define HMS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define HMS_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`else

`define HMS_ASSERT(label, prop, msg)

`define HMS_ASSERT_NEXT(label, pre, post, msg)

`endif

`endif

/* hw/rtl/hms_pkg.sv */
package hms_pkg;

	localparam int DATA_W       = 32;
	localparam int CFG_W        = 6;
	localparam int CFG_IDX_W    = 2;
	localparam int POS_W        = CFG_W + 1;
	localparam int SIZE_LIMIT   = (1 << CFG_W) - 1;
	localparam int DEF_MAX_SIZE = 62;

	localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

	// weighted sum 14c + 2(zm+zp) + six stays below 24 * 2^(DATA_W-1)
	localparam int SUM_W = DATA_W + 5;

	// (|sum| + 12) >> 3 is then divided by three through a reciprocal
	localparam int QUO_IN_W = DATA_W + 1;
	localparam int QUO_LO_W = QUO_IN_W / 2;
	localparam int QUO_HI_W = QUO_IN_W - QUO_LO_W;
	localparam logic [63:0] RECIP_WIDE = ((64'd1 << (QUO_IN_W + 1)) / 64'd3) + 64'd1;
	localparam logic [QUO_IN_W-1:0] RECIP = RECIP_WIDE[QUO_IN_W-1:0];

	localparam int QUEUE_DEPTH = 8;
	localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);

	typedef logic signed [DATA_W-1:0] sample_t;
	typedef logic signed [SUM_W-1:0]  sum_t;

	typedef struct packed {
		sum_t sum;
		logic last;
	} job_t;

	function automatic logic [CFG_W-1:0] clamp_size(logic [CFG_W-1:0] value,
			logic [CFG_W-1:0] limit);
		return (value > limit) ? limit : value;
	endfunction

endpackage

/* hw/rtl/hms_in_if.sv */
interface hms_in_if import hms_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

/* hw/rtl/hms_out_if.sv */
interface hms_out_if import hms_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t result;
	logic    last;

	modport source (output valid, output result, output last, input ready);
	modport sink (input valid, input result, input last, output ready);
endinterface

/* hw/rtl/hms_delay.sv */
module hms_delay import hms_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         restart,
	input  logic                         en,
	input  logic [$clog2(DEPTH+1)-1:0]   len,
	input  sample_t                      din,
	output sample_t                      dout
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LW = $clog2(DEPTH + 1);

	sample_t        mem [DEPTH];
	sample_t        rd_q;
	sample_t        byp_q;
	logic [AW-1:0]  ptr_q;
	logic [LW-1:0]  ptr_inc;
	logic           use_mem;

	assign use_mem = (len != '0);
	assign ptr_inc = LW'(ptr_q) + LW'(1);

	// read-first: the word leaving is the one written len advances ago
	always_ff @(posedge clk) begin
		if (en && use_mem) begin
			mem[ptr_q] <= din;
		end
		if (en) begin
			rd_q  <= mem[ptr_q];
			byp_q <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (restart) begin
			ptr_q <= '0;
		end else if (en && use_mem) begin
			ptr_q <= (ptr_inc >= len) ? '0 : ptr_q + AW'(1);
		end
	end

	assign dout = use_mem ? rd_q : byp_q;

endmodule

/* hw/rtl/hms_front.sv */
module hms_front import hms_pkg::*; #(
	parameter int MAX_SIZE_X = DEF_MAX_SIZE,
	parameter int MAX_SIZE_Y = DEF_MAX_SIZE,
	parameter int MAX_SIZE_Z = DEF_MAX_SIZE
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	hms_in_if.sink               samples,
	input  logic [LEVEL_W-1:0]   q_level,
	output logic                 push,
	output job_t                 job
);

	localparam int EFF_X   = (MAX_SIZE_X < SIZE_LIMIT) ? MAX_SIZE_X : SIZE_LIMIT;
	localparam int EFF_Y   = (MAX_SIZE_Y < SIZE_LIMIT) ? MAX_SIZE_Y : SIZE_LIMIT;
	localparam int EFF_Z   = (MAX_SIZE_Z < SIZE_LIMIT) ? MAX_SIZE_Z : SIZE_LIMIT;
	localparam int RST_X   = (EFF_X < DEF_MAX_SIZE) ? EFF_X : DEF_MAX_SIZE;
	localparam int RST_Y   = (EFF_Y < DEF_MAX_SIZE) ? EFF_Y : DEF_MAX_SIZE;
	localparam int RST_Z   = (EFF_Z < DEF_MAX_SIZE) ? EFF_Z : DEF_MAX_SIZE;
	localparam int ROW_MAX = EFF_Z + 2;
	localparam int DEPTH_A = ROW_MAX;
	localparam int DEPTH_B = ROW_MAX * EFF_Y;
	localparam int LW_A    = $clog2(DEPTH_A + 1);
	localparam int LW_B    = $clog2(DEPTH_B + 1);
	localparam int PROD_W  = POS_W + CFG_W;

	logic [CFG_W-1:0] size_x_q, size_y_q, size_z_q;
	logic [POS_W-1:0] pos_x_q, pos_y_q, pos_z_q;
	logic [POS_W-1:0] x_end, y_end, z_end, size_x_e, size_y_e, size_z_e;
	logic [POS_W-1:0] row, len_row_m1;
	logic [PROD_W-1:0] row_by_y, len_body;
	logic             restart, acc, emit, is_last;
	logic [LEVEL_W:0] credit;

	sample_t tap_row, tap_pmr, tap_pm1, tap_ppr, tap_smr, tap_span;
	sample_t centre_q, zhi_q;

	logic    v_s1_q, v_s2_q, v_s3_q;
	logic    last_s1, last_s2, last_s3;
	sample_t s_s1, row_s1, pmr_s1, pm1_s1, c_s1, pp1_s1, ppr_s1, smr_s1, span_s1;
	sum_t    a_s2, b_s2, d_s2, sum_s3;

	// configuration; any size write starts a fresh grid
	assign restart = cfg_wr_en && (cfg_index == REG_SIZE_X || cfg_index == REG_SIZE_Y ||
		cfg_index == REG_SIZE_Z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= CFG_W'(RST_X);
			size_y_q <= CFG_W'(RST_Y);
			size_z_q <= CFG_W'(RST_Z);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_SIZE_X: size_x_q <= clamp_size(cfg_data, CFG_W'(EFF_X));
				REG_SIZE_Y: size_y_q <= clamp_size(cfg_data, CFG_W'(EFF_Y));
				REG_SIZE_Z: size_z_q <= clamp_size(cfg_data, CFG_W'(EFF_Z));
				default: ;
			endcase
		end
	end

	// room in the queue for everything already on its way there
	assign credit = {1'b0, q_level} + (LEVEL_W+1)'(v_s1_q) + (LEVEL_W+1)'(v_s2_q) +
		(LEVEL_W+1)'(v_s3_q);
	assign samples.ready = credit < (LEVEL_W+1)'(QUEUE_DEPTH);
	assign acc = samples.valid && samples.ready;

	assign size_x_e = POS_W'(size_x_q);
	assign size_y_e = POS_W'(size_y_q);
	assign size_z_e = POS_W'(size_z_q);
	assign x_end    = size_x_e + POS_W'(1);
	assign y_end    = size_y_e + POS_W'(1);
	assign z_end    = size_z_e + POS_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			pos_z_q <= '0;
		end else if (restart) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			pos_z_q <= '0;
		end else if (acc) begin
			if (pos_z_q == z_end) begin
				pos_z_q <= '0;
				if (pos_y_q == y_end) begin
					pos_y_q <= '0;
					pos_x_q <= (pos_x_q == x_end) ? '0 : pos_x_q + POS_W'(1);
				end else begin
					pos_y_q <= pos_y_q + POS_W'(1);
				end
			end else begin
				pos_z_q <= pos_z_q + POS_W'(1);
			end
		end
	end

	// the sample one step on in x completes the point behind it
	assign emit = (pos_x_q >= POS_W'(2)) && (pos_x_q <= x_end) &&
		(pos_y_q != '0) && (pos_y_q <= size_y_e) &&
		(pos_z_q != '0) && (pos_z_q <= size_z_e);
	assign is_last = (pos_x_q == x_end) && (pos_y_q == size_y_e) && (pos_z_q == size_z_e);

	// delay line lengths; each segment adds one for its output register
	assign row        = size_z_e + POS_W'(2);
	assign len_row_m1 = size_z_e + POS_W'(1);
	assign row_by_y   = PROD_W'(row) * PROD_W'(size_y_q);
	assign len_body   = (row_by_y == '0) ? '0 : row_by_y - PROD_W'(1);

	hms_delay #(.DEPTH(DEPTH_A)) u_dly_row (
		.clk(clk), .arst_n(arst_n), .restart(restart), .en(acc),
		.len(LW_A'(len_row_m1)), .din(samples.sample), .dout(tap_row)
	);

	hms_delay #(.DEPTH(DEPTH_B)) u_dly_pmr (
		.clk(clk), .arst_n(arst_n), .restart(restart), .en(acc),
		.len(LW_B'(len_body)), .din(tap_row), .dout(tap_pmr)
	);

	hms_delay #(.DEPTH(DEPTH_A)) u_dly_pm1 (
		.clk(clk), .arst_n(arst_n), .restart(restart), .en(acc),
		.len(LW_A'(size_z_e)), .din(tap_pmr), .dout(tap_pm1)
	);

	always_ff @(posedge clk) begin
		if (acc) begin
			centre_q <= tap_pm1;
			zhi_q    <= centre_q;
		end
	end

	hms_delay #(.DEPTH(DEPTH_A)) u_dly_ppr (
		.clk(clk), .arst_n(arst_n), .restart(restart), .en(acc),
		.len(LW_A'(size_z_e)), .din(zhi_q), .dout(tap_ppr)
	);

	hms_delay #(.DEPTH(DEPTH_B)) u_dly_smr (
		.clk(clk), .arst_n(arst_n), .restart(restart), .en(acc),
		.len(LW_B'(len_body)), .din(tap_ppr), .dout(tap_smr)
	);

	hms_delay #(.DEPTH(DEPTH_A)) u_dly_span (
		.clk(clk), .arst_n(arst_n), .restart(restart), .en(acc),
		.len(LW_A'(len_row_m1)), .din(tap_smr), .dout(tap_span)
	);

	// three-stage sum: taps, partial sums, full weighted sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
			v_s2_q <= 1'b0;
			v_s3_q <= 1'b0;
		end else begin
			v_s1_q <= acc && emit;
			v_s2_q <= v_s1_q;
			v_s3_q <= v_s2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			s_s1    <= samples.sample;
			row_s1  <= tap_row;
			pmr_s1  <= tap_pmr;
			pm1_s1  <= tap_pm1;
			c_s1    <= centre_q;
			pp1_s1  <= zhi_q;
			ppr_s1  <= tap_ppr;
			smr_s1  <= tap_smr;
			span_s1 <= tap_span;
			last_s1 <= is_last;
		end
		a_s2    <= (sum_t'(c_s1) <<< 3) - sum_t'(c_s1) + sum_t'(pm1_s1) + sum_t'(pp1_s1);
		b_s2    <= sum_t'(s_s1) + sum_t'(row_s1) + sum_t'(ppr_s1);
		d_s2    <= sum_t'(span_s1) + sum_t'(smr_s1) + sum_t'(pmr_s1);
		last_s2 <= last_s1;
		sum_s3  <= (a_s2 <<< 1) + b_s2 + d_s2;
		last_s3 <= last_s2;
	end

	assign push     = v_s3_q;
	assign job.sum  = sum_s3;
	assign job.last = last_s3;

endmodule

/* hw/rtl/hms_queue.sv */
`include "assert_macros.svh"

module hms_queue import hms_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  job_t               job_in,
	input  logic               pop,
	output job_t               job_out,
	output logic               nonempty,
	output logic [LEVEL_W-1:0] level
);

	localparam int QA_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	job_t               mem [QUEUE_DEPTH];
	logic [QA_W-1:0]    wr_q, rd_q;
	logic [LEVEL_W-1:0] level_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= job_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			level_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QA_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + QA_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == QA_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + QA_W'(1);
			end
			if (push && !pop) begin
				level_q <= level_q + LEVEL_W'(1);
			end else if (pop && !push) begin
				level_q <= level_q - LEVEL_W'(1);
			end
		end
	end

	assign job_out  = mem[rd_q];
	assign nonempty = (level_q != '0);
	assign level    = level_q;

	`HMS_ASSERT(a_no_overflow, push |-> level_q != LEVEL_W'(QUEUE_DEPTH), "queue overflow")
	`HMS_ASSERT(a_no_underflow, pop |-> level_q != '0, "pop from empty queue")
	`HMS_ASSERT_NEXT(a_level_grows, push && !pop, level_q == $past(level_q) + LEVEL_W'(1), "queue level lost a word")

endmodule

/* hw/rtl/hms_back.sv */
module hms_back import hms_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     job_valid,
	input  job_t     job,
	output logic     pop,
	hms_out_if.source results
);

	localparam int ROUND_BIAS = 12;
	localparam int DIV8_SHIFT = 3;
	localparam int PL_W       = QUO_LO_W + QUO_IN_W;
	localparam int PH_W       = QUO_HI_W + QUO_IN_W;
	localparam int PROD_W     = QUO_IN_W + QUO_IN_W;
	localparam logic [DATA_W-1:0] SAT_HI = {1'b0, {(DATA_W-1){1'b1}}};

	logic                en;
	logic [SUM_W-1:0]    mag, mag_rnd;
	logic [DATA_W-1:0]   quo;

	logic                v_b1_q, v_b2_q, v_b3_q, out_valid_q;
	logic                neg_b1, neg_b2, neg_b3;
	logic                last_b1, last_b2, last_b3, last_q;
	logic [QUO_IN_W-1:0] x_b1;
	logic [PL_W-1:0]     pl_b2;
	logic [PH_W-1:0]     ph_b2;
	logic [PROD_W-1:0]   prod_b3;
	logic [DATA_W-1:0]   result_q;

	// whole pipeline moves together unless the output word is held
	assign en  = !out_valid_q || results.ready;
	assign pop = en && job_valid;

	assign mag     = job.sum[SUM_W-1] ? SUM_W'(-job.sum) : SUM_W'(job.sum);
	assign mag_rnd = mag + SUM_W'(ROUND_BIAS);
	assign quo     = prod_b3[PROD_W-1:QUO_IN_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1_q      <= 1'b0;
			v_b2_q      <= 1'b0;
			v_b3_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_b1_q      <= job_valid;
			v_b2_q      <= v_b1_q;
			v_b3_q      <= v_b2_q;
			out_valid_q <= v_b3_q;
		end
	end

	// divide by 24: shift out 8, then multiply by the reciprocal of three in two halves
	always_ff @(posedge clk) begin
		if (en) begin
			x_b1    <= mag_rnd[QUO_IN_W+DIV8_SHIFT-1:DIV8_SHIFT];
			neg_b1  <= job.sum[SUM_W-1];
			last_b1 <= job.last;

			pl_b2   <= x_b1[QUO_LO_W-1:0] * RECIP;
			ph_b2   <= x_b1[QUO_IN_W-1:QUO_LO_W] * RECIP;
			neg_b2  <= neg_b1;
			last_b2 <= last_b1;

			prod_b3 <= {ph_b2, {QUO_LO_W{1'b0}}} + PROD_W'(pl_b2);
			neg_b3  <= neg_b2;
			last_b3 <= last_b2;

			result_q <= neg_b3 ? (~quo + DATA_W'(1)) : ((quo > SAT_HI) ? SAT_HI : quo);
			last_q   <= last_b3;
		end
	end

	assign results.valid  = out_valid_q;
	assign results.result = result_q;
	assign results.last   = last_q;

endmodule

/* hw/rtl/hex_mehrstellen_rhs_stencil.sv */
// hexagonal mehrstellen right-hand side, one padded grid sample in per word
// samples: padded grid of (size_x+2)(size_y+2)(size_z+2) values, x slowest, z fastest,
//   signed q15.16; results: one word per interior point, last marks the grid's final one
// cfg_wr_en/cfg_index/cfg_data write size_x, size_y, size_z (indices 0..2) while idle;
//   a size write restarts the grid, values above the maximum saturate
// a result follows the sample one step further on in x; from that sample it passes
//   3 sum stages, the queue and 4 divide stages; the back end waits while the output is held
// throughput: one sample per cycle sustained; the front takes samples while an
//   8-word queue has room for every result already in flight
// the two-plane history sits in six delay-line memories that advance only on
//   accepted samples, so input idle cycles cost nothing
// reset: sizes return to 62 (or the configured maximum), positions to zero;
//   no clearing pass, the history is only read once two full planes have arrived
// results.ready low holds the output word and stalls the back end; the queue then
//   fills and samples.ready drops, nothing is lost or repeated
module hex_mehrstellen_rhs_stencil import hms_pkg::*; #(
	parameter int MAX_SIZE_X = DEF_MAX_SIZE,
	parameter int MAX_SIZE_Y = DEF_MAX_SIZE,
	parameter int MAX_SIZE_Z = DEF_MAX_SIZE
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	hms_in_if.sink               samples,
	hms_out_if.source            results
);

	logic               push, pop, nonempty;
	job_t               job_in, job_out;
	logic [LEVEL_W-1:0] level;

	hms_front #(
		.MAX_SIZE_X(MAX_SIZE_X),
		.MAX_SIZE_Y(MAX_SIZE_Y),
		.MAX_SIZE_Z(MAX_SIZE_Z)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.samples(samples),
		.q_level(level),
		.push(push),
		.job(job_in)
	);

	hms_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.job_in(job_in),
		.pop(pop),
		.job_out(job_out),
		.nonempty(nonempty),
		.level(level)
	);

	hms_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.job_valid(nonempty),
		.job(job_out),
		.pop(pop),
		.results(results)
	);

endmodule
